### hdl/ps2dft_pkg.sv
package ps2dft_pkg;

    localparam int TICK_W       = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int PHASE_W      = 3;
    localparam int BITPOS_W     = 4;
    localparam int FRAME_W      = 11;
    localparam int DEF_QUEUE_DEPTH = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEAD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP   = 2'd2;

    localparam logic [TICK_W-1:0] RST_LEAD_TICKS  = 16'd500;
    localparam logic [TICK_W-1:0] RST_PHASE_TICKS = 16'd200;
    localparam logic [TICK_W-1:0] RST_GAP_TICKS   = 16'd2000;

    localparam logic [BITPOS_W-1:0] FRAME_LEN = 4'd11;

    typedef struct packed {
        logic line_clock;
        logic line_data;
        logic sending;
    } line_lvl_t;

    typedef struct packed {
        line_lvl_t lvl;
        logic      dropped;
    } res_t;

    // a zero count still waits one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

### hdl/ps2dft_queue.sv
module ps2dft_queue #(
    parameter int DEPTH = ps2dft_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_try,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic [7:0] head_byte,
    output logic       nonempty,
    output logic       dropped
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    head_byte_reg;
    logic          push;

    // a pop in the same word frees a slot for the push
    assign push     = push_try && !((count_reg == CW'(DEPTH)) && !pop);
    assign dropped  = push_try && !push;
    assign nonempty = (count_reg != '0);
    assign head_byte = head_byte_reg;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop) begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage with a registered look-ahead read of the next head entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
        if (push && (tail_reg == head_next)) begin
            head_byte_reg <= push_data;
        end else begin
            head_byte_reg <= mem[head_next];
        end
    end

endmodule

### hdl/ps2dft_line.sv
module ps2dft_line (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          nonempty,
    input  logic [7:0]                    head_byte,
    input  logic [ps2dft_pkg::TICK_W-1:0] lead_ticks,
    input  logic [ps2dft_pkg::TICK_W-1:0] phase_ticks,
    input  logic [ps2dft_pkg::TICK_W-1:0] gap_ticks,
    output logic                          pop,
    output ps2dft_pkg::line_lvl_t         lvl
);

    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_LEAD     = 3'd1;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_CLK_HIGH = 3'd2;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_DATA     = 3'd3;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_CLK_LOW  = 3'd4;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_TAIL     = 3'd5;
    localparam logic [ps2dft_pkg::PHASE_W-1:0] PH_GAP      = 3'd6;

    logic [ps2dft_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [ps2dft_pkg::TICK_W-1:0]   wait_reg, wait_next;
    logic [ps2dft_pkg::BITPOS_W-1:0] bitpos_reg, bitpos_next;
    logic [ps2dft_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic                            clk_reg, clk_next;
    logic                            data_reg, data_next;
    logic                            start;
    logic [15:0]                     frame_ext;

    assign frame_ext = {{(16 - ps2dft_pkg::FRAME_W){1'b0}}, frame_reg};

    always_comb begin
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        bitpos_next = bitpos_reg;
        frame_next  = frame_reg;
        clk_next    = clk_reg;
        data_next   = data_reg;
        start       = 1'b0;
        if ((phase_reg != PH_IDLE) && (wait_reg > 16'd1)) begin
            wait_next = wait_reg - 1'b1;
        end else begin
            case (phase_reg)
                PH_LEAD: begin
                    bitpos_next = '0;
                    clk_next    = 1'b1;
                    phase_next  = PH_CLK_HIGH;
                    wait_next   = ps2dft_pkg::at_least_one(phase_ticks);
                end
                PH_CLK_HIGH: begin
                    data_next  = frame_ext[bitpos_reg];
                    phase_next = PH_DATA;
                    wait_next  = ps2dft_pkg::at_least_one(phase_ticks);
                end
                PH_DATA: begin
                    clk_next   = 1'b0;
                    phase_next = PH_CLK_LOW;
                    wait_next  = ps2dft_pkg::at_least_one(phase_ticks);
                end
                PH_CLK_LOW: begin
                    bitpos_next = bitpos_reg + 1'b1;
                    if (bitpos_next < ps2dft_pkg::FRAME_LEN) begin
                        clk_next   = 1'b1;
                        phase_next = PH_CLK_HIGH;
                    end else begin
                        phase_next = PH_TAIL;
                    end
                    wait_next = ps2dft_pkg::at_least_one(phase_ticks);
                end
                PH_TAIL: begin
                    clk_next   = 1'b1;
                    data_next  = 1'b1;
                    phase_next = PH_GAP;
                    wait_next  = ps2dft_pkg::at_least_one(gap_ticks);
                end
                default: begin
                    // idle or gap done: both lines high, start next byte if any
                    clk_next  = 1'b1;
                    data_next = 1'b1;
                    if (nonempty) begin
                        start       = 1'b1;
                        // stop, odd parity, data lsb first, start
                        frame_next  = {1'b1, ~^head_byte, head_byte, 1'b0};
                        bitpos_next = '0;
                        phase_next  = PH_LEAD;
                        wait_next   = ps2dft_pkg::at_least_one(lead_ticks);
                    end else begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                    end
                end
            endcase
        end
    end

    assign pop            = step && start;
    assign lvl.line_clock = clk_next;
    assign lvl.line_data  = data_next;
    assign lvl.sending    = (phase_next != PH_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            wait_reg   <= '0;
            bitpos_reg <= '0;
            frame_reg  <= '0;
            clk_reg    <= 1'b1;
            data_reg   <= 1'b1;
        end else if (step) begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            bitpos_reg <= bitpos_next;
            frame_reg  <= frame_next;
            clk_reg    <= clk_next;
            data_reg   <= data_next;
        end
    end

endmodule

### hdl/ps2_device_frame_transmitter_unit.sv
// PS/2 device-side transmitter, advanced one tick per accepted input word.
// Each input word is one tick: it may carry a scan code (s_has_code) that is
// queued in a QUEUE_DEPTH-byte FIFO and is first seen by the line sequencer on
// the following tick. Queued bytes go out as 11-bit frames (start 0, eight data
// bits lsb first, odd parity, stop 1): a lead wait with both lines high, three
// phases per bit (clock high, data driven, clock low), a tail phase, then an
// idle gap. Each wait lasts its register's tick count, a count of zero acting
// as one. Every input word yields exactly one result word carrying the line
// levels for that tick, a sending flag and a dropped flag for a byte lost to a
// full FIFO. One word is taken per clock cycle while the skid entry is empty;
// each result is registered into the output register, or into the skid entry
// when the output stalls. A two-entry output buffer lets input words keep
// flowing while one result waits. Registers: index 0 lead_ticks (reset 500),
// 1 phase_ticks (reset 200), 2 gap_ticks (reset 2000); other indexes ignored.
// Write registers only while idle.
module ps2_device_frame_transmitter_unit #(
    parameter int QUEUE_DEPTH = ps2dft_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [ps2dft_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ps2dft_pkg::TICK_W-1:0]     cfg_wdata,
    // tick input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_has_code,
    input  logic [7:0]                        s_scan_code,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_line_clock,
    output logic                              m_line_data,
    output logic                              m_sending,
    output logic                              m_dropped
);

    logic [ps2dft_pkg::TICK_W-1:0] lead_reg;
    logic [ps2dft_pkg::TICK_W-1:0] phase_reg;
    logic [ps2dft_pkg::TICK_W-1:0] gap_reg;

    logic                  accept;
    logic                  pop;
    logic                  nonempty;
    logic                  dropped;
    logic [7:0]            head_byte;
    ps2dft_pkg::line_lvl_t lvl;
    ps2dft_pkg::res_t      res;

    // output register plus skid entry
    ps2dft_pkg::res_t out_reg;
    ps2dft_pkg::res_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg  <= ps2dft_pkg::RST_LEAD_TICKS;
            phase_reg <= ps2dft_pkg::RST_PHASE_TICKS;
            gap_reg   <= ps2dft_pkg::RST_GAP_TICKS;
        end else if (cfg_we) begin
            case (cfg_addr)
                ps2dft_pkg::REG_LEAD:  lead_reg  <= cfg_wdata;
                ps2dft_pkg::REG_PHASE: phase_reg <= cfg_wdata;
                ps2dft_pkg::REG_GAP:   gap_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // line sequencer steps first, then the offered byte is queued
    ps2dft_line u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .nonempty    (nonempty),
        .head_byte   (head_byte),
        .lead_ticks  (lead_reg),
        .phase_ticks (phase_reg),
        .gap_ticks   (gap_reg),
        .pop         (pop),
        .lvl         (lvl)
    );

    ps2dft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_try  (accept && s_has_code),
        .push_data (s_scan_code),
        .pop       (pop),
        .head_byte (head_byte),
        .nonempty  (nonempty),
        .dropped   (dropped)
    );

    assign res.lvl     = lvl;
    assign res.dropped = dropped;

    // result buffering: main slot feeds the port, skid catches a word on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_ready || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_line_clock = out_reg.lvl.line_clock;
    assign m_line_data  = out_reg.lvl.line_data;
    assign m_sending    = out_reg.lvl.sending;
    assign m_dropped    = out_reg.dropped;

endmodule
